### rtl/ordered_set_table_defines.svh
// Assertion macros for the ordered set table RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ORDERED_SET_TABLE_DEFINES_SVH
`define ORDERED_SET_TABLE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define OST_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered_set_table check failed");

// next-cycle implication, disabled in reset
`define OST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered_set_table check failed");

`endif

### rtl/ost_pkg.sv
// Shared types and codes for the ordered set table.
// No dependencies.
package ost_pkg;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_PRESENT = 2'd1;
   localparam logic [1:0] STATUS_ABSENT  = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   localparam int VALUE_W    = 32;
   localparam int SET_SIZE_W = 5;
   localparam int RSP_W      = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_EXEC,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

endpackage

### rtl/ost_entry_ram.sv
// Entry store of the ordered set table: one write port, one registered read port.
// No dependencies.
module ost_entry_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ordered_set_table.sv
// Ordered set table top level: sequencer over a two-port entry store.
// Depends on ost_pkg, ost_entry_ram and ordered_set_table_defines.svh.
//
// Usage:
//   Requests enter on req_: req_tuser carries the function (insert, remove,
//   lookup; code three acts as lookup), req_tdata the 32-bit value.
//   Each request gives one word on rsp_: found, status and set size.
//   One request is in work at a time; req_tready is high only while the
//   sequencer is idle. A finished word waits in the output register, so a
//   new request is taken while rsp_ is stalled.
//   A lookup, insert or remove scans the held entries in order up to a
//   match or the end of the set; a remove hit then shifts the tail down.
//   Each compare and each shift step reads the one read port of the store.
//   Reset empties the set and drops any pending response word; the entry
//   store itself is not cleared, and no entry at or above the count is read.
//   While rsp_tready is low a finished result holds in the output register
//   and the sequencer waits before loading the next one.
`include "ordered_set_table_defines.svh"

module ordered_set_table #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // found[0], status[2:1], set_size[7:3]
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   ost_pkg::state_type state_ff, state_in;
   logic [1:0]              func_ff, func_in;
   logic [ost_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    found_ff, found_in;
   logic [1:0]              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ost_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [ost_pkg::VALUE_W-1:0] wr_data;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [ost_pkg::VALUE_W-1:0] rd_data;

   logic [CNT_W-1:0]        idx_nxt;
   logic [CNT_W:0]          idx_nxt2;
   logic [CNT_W+ost_pkg::SET_SIZE_W-1:0] count_ext;
   logic [ost_pkg::SET_SIZE_W-1:0] set_size;

   assign idx_nxt   = idx_ff + 1'b1;
   assign idx_nxt2  = {1'b0, idx_ff} + 2'd2;
   assign count_ext = {{ost_pkg::SET_SIZE_W{1'b0}}, count_ff};
   assign set_size  = count_ext[ost_pkg::SET_SIZE_W-1:0];

   ost_entry_ram #(
      .DEPTH  (CAPACITY),
      .WIDTH  (ost_pkg::VALUE_W),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ost_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      value_ff    <= value_in;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IDX_W-1:0];
      wr_data      = value_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[IDX_W-1:0];
      req_tready   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ost_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in  = req_tuser;
               value_in = req_tdata;
               idx_in   = '0;
               found_in = 1'b0;
               state_in = (count_ff == '0) ? ost_pkg::ST_EXEC : ost_pkg::ST_SCAN_RD;
            end
         end
         ost_pkg::ST_SCAN_RD: begin
            rd_en    = 1'b1;
            state_in = ost_pkg::ST_SCAN_CMP;
         end
         ost_pkg::ST_SCAN_CMP: begin
            if (rd_data == value_ff) begin
               found_in = 1'b1;
               state_in = ost_pkg::ST_EXEC;
            end else begin
               idx_in   = idx_nxt;
               state_in = (idx_nxt == count_ff) ? ost_pkg::ST_EXEC : ost_pkg::ST_SCAN_RD;
            end
         end
         ost_pkg::ST_EXEC: begin
            state_in = ost_pkg::ST_DONE;
            unique case (func_ff)
               ost_pkg::FUNC_INSERT: begin
                  if (found_ff) begin
                     status_in = ost_pkg::STATUS_PRESENT;
                  end else if (count_ff == CNT_W'(CAPACITY)) begin
                     status_in = ost_pkg::STATUS_FULL;
                  end else begin
                     wr_en     = 1'b1;
                     wr_addr   = count_ff[IDX_W-1:0];
                     count_in  = count_ff + 1'b1;
                     status_in = ost_pkg::STATUS_OK;
                  end
               end
               ost_pkg::FUNC_REMOVE: begin
                  if (found_ff) begin
                     status_in = ost_pkg::STATUS_OK;
                     if (idx_nxt < count_ff) begin
                        state_in = ost_pkg::ST_SHIFT_RD;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end else begin
                     status_in = ost_pkg::STATUS_ABSENT;
                  end
               end
               default: begin
                  status_in = found_ff ? ost_pkg::STATUS_OK : ost_pkg::STATUS_ABSENT;
               end
            endcase
         end
         ost_pkg::ST_SHIFT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_nxt[IDX_W-1:0];
            state_in = ost_pkg::ST_SHIFT_WR;
         end
         ost_pkg::ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            idx_in  = idx_nxt;
            if (idx_nxt2 < {1'b0, count_ff}) begin
               state_in = ost_pkg::ST_SHIFT_RD;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = ost_pkg::ST_DONE;
            end
         end
         ost_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {set_size, status_ff, found_ff};
               state_in     = ost_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ost_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `OST_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `OST_ASSERT_NEXT(a_idle_count_hold, clock, reset, state_ff == ost_pkg::ST_IDLE,
                    count_ff == $past(count_ff))
   `OST_ASSERT_IMPL(a_found_status, clock, reset, rsp_tvalid && rsp_tdata[0],
                    rsp_tdata[2:1] == ost_pkg::STATUS_OK ||
                    rsp_tdata[2:1] == ost_pkg::STATUS_PRESENT)
   `OST_ASSERT_IMPL(a_full_not_found, clock, reset,
                    rsp_tvalid && rsp_tdata[2:1] == ost_pkg::STATUS_FULL, !rsp_tdata[0])

endmodule

### tb/ordered_set_table_tb.sv
// Self-checking testbench for ordered_set_table: a directed table, then random
// insert/remove/lookup traffic checked against an in-bench set model.
// Depends on ost_pkg and the ordered_set_table RTL.
`timescale 1ns / 1ps

module ordered_set_table_tb;

   localparam int SET_DEPTH = 16;
   localparam int RANDOM_WORDS = 950;
   localparam int POOL_SIZE = 24;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 4 * SET_DEPTH + 8;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   typedef struct packed {
      logic       found;
      logic [1:0] status;
      logic [4:0] set_size;
   } result_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] value;
      logic        typed;
      result_type  want;
   } plan_row_type;

   localparam int PLAN_ROWS = 25;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // value[31:0]
   logic [1:0]  req_tuser = '0;    // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // found[0], status[2:1], set_size[7:3]

   logic [31:0] held_values [SET_DEPTH];
   int          held_count;
   result_type  pending_results [$];
   int          mismatch_count;
   logic        steady;
   int          quiet_cycles;
   logic [31:0] value_pool [POOL_SIZE];

   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{ost_pkg::FUNC_LOOKUP, 32'h0000_0000, 1'b1, '{1'b0, ost_pkg::STATUS_ABSENT, 5'd0}},
      '{ost_pkg::FUNC_REMOVE, 32'h1234_5678, 1'b1, '{1'b0, ost_pkg::STATUS_ABSENT, 5'd0}},
      '{ost_pkg::FUNC_INSERT, 32'h8000_0000, 1'b1, '{1'b0, ost_pkg::STATUS_OK, 5'd1}},
      '{ost_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b0, ost_pkg::STATUS_OK, 5'd2}},
      '{ost_pkg::FUNC_INSERT, 32'h8000_0000, 1'b1, '{1'b1, ost_pkg::STATUS_PRESENT, 5'd2}},
      '{FUNC_SPARE,           32'h7FFF_FFFF, 1'b1, '{1'b1, ost_pkg::STATUS_OK, 5'd2}},
      '{ost_pkg::FUNC_INSERT, 32'h0000_0000, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'h5555_5555, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'h0000_0001, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'h0000_0002, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'h0000_0003, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'h0000_0004, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'h0000_0005, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'h0000_0006, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'h0000_0007, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'h0000_0008, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'h0000_0009, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'h0000_000A, 1'b0, '0},
      '{ost_pkg::FUNC_INSERT, 32'hDEAD_BEEF, 1'b1, '{1'b0, ost_pkg::STATUS_FULL, 5'd16}},
      '{ost_pkg::FUNC_INSERT, 32'h8000_0000, 1'b1, '{1'b1, ost_pkg::STATUS_PRESENT, 5'd16}},
      '{ost_pkg::FUNC_REMOVE, 32'h8000_0000, 1'b1, '{1'b1, ost_pkg::STATUS_OK, 5'd15}},
      '{ost_pkg::FUNC_LOOKUP, 32'h8000_0000, 1'b1, '{1'b0, ost_pkg::STATUS_ABSENT, 5'd15}},
      '{ost_pkg::FUNC_REMOVE, 32'h5555_5555, 1'b0, '0}
   };

   ordered_set_table #(.CAPACITY(SET_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic result_type apply_request(input logic [1:0] func,
                                                input logic [31:0] value);
      result_type r;
      int      pos;
      int      i;
      pos = -1;
      for (i = 0; i < held_count; i++)
         if (pos < 0 && held_values[i] == value) pos = i;
      r.found = (pos >= 0);
      case (func)
         ost_pkg::FUNC_INSERT: begin
            if (pos >= 0) begin
               r.status = ost_pkg::STATUS_PRESENT;
            end else if (held_count >= SET_DEPTH) begin
               r.status = ost_pkg::STATUS_FULL;
            end else begin
               held_values[held_count] = value;
               held_count++;
               r.status = ost_pkg::STATUS_OK;
            end
         end
         ost_pkg::FUNC_REMOVE: begin
            if (pos >= 0) begin
               for (i = pos; i + 1 < held_count; i++) held_values[i] = held_values[i + 1];
               held_count--;
               r.status = ost_pkg::STATUS_OK;
            end else begin
               r.status = ost_pkg::STATUS_ABSENT;
            end
         end
         default: r.status = (pos >= 0) ? ost_pkg::STATUS_OK : ost_pkg::STATUS_ABSENT;
      endcase
      r.set_size = held_count[4:0];
      return r;
   endfunction

   // enter and leave at a falling edge
   task automatic send_word(input logic [1:0] func, input logic [31:0] value,
                            input logic typed, input result_type want);
      result_type predicted;
      while (!steady && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      predicted = apply_request(func, value);
      if (typed) predicted = want;
      pending_results = {pending_results, predicted};
      @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_tready <= steady ? 1'b1 : ($urandom_range(99) >= 36);

   always @(posedge clock) begin : rsp_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[0], rsp_tdata[2:1], rsp_tdata[7:3]};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $time, got);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.found !== want.found) begin
               $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
               mismatch_count++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
               mismatch_count++;
            end
            if (got.set_size !== want.set_size) begin
               $display("%0t: set_size expected %0d actual %0d", $time, want.set_size,
                        got.set_size);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [1:0]  func;
      logic [31:0] value;
      int          pick;
      int          bias;
      held_count = 0;
      steady = 1'b0;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i])
         send_word(directed_plan[i].func, directed_plan[i].value, directed_plan[i].typed,
                   directed_plan[i].want);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 50 == 0 && n % 200 == 100) begin
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end
         steady = (n >= 300 && n < 450);
         // alternate fill-heavy and drain-heavy phases
         bias = ((n / 50) % 2 == 0) ? 60 : 15;
         pick = $urandom_range(99);
         if (pick < bias) func = ost_pkg::FUNC_INSERT;
         else if (pick < bias + 25) func = ost_pkg::FUNC_REMOVE;
         else if (pick < 95) func = ost_pkg::FUNC_LOOKUP;
         else func = FUNC_SPARE;
         pick = $urandom_range(99);
         if (pick < 35 && held_count > 0)
            value = held_values[$urandom_range(held_count - 1)];
         else if (pick < 85)
            value = value_pool[$urandom_range(POOL_SIZE - 1)];
         else
            value = $urandom;
         send_word(func, value, 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/ost_pkg.sv
rtl/ost_entry_ram.sv
rtl/ordered_set_table.sv
tb/ordered_set_table_tb.sv
